### design/mersenne_twister_generator_unit_defines.svh
// Assertion macros shared by the generator RTL
`ifndef MERSENNE_TWISTER_GENERATOR_UNIT_DEFINES_SVH
`define MERSENNE_TWISTER_GENERATOR_UNIT_DEFINES_SVH

// Same-cycle implication, checked outside reset
`define MTG_ASSERT_NOW(label, ante, cons) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("mtg check failed");

// Next-cycle implication, checked outside reset
`define MTG_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("mtg check failed");

`endif

### design/mtg_pkg.sv
`default_nettype none

package mtg_pkg;

  // Request codes
  localparam logic REQ_DRAW = 1'b0;
  localparam logic REQ_SEED = 1'b1;

  // Recurrence constants
  localparam int unsigned SHIFT_M    = 397;
  localparam logic [31:0] INIT_MULT  = 32'd1812433253;
  localparam logic [31:0] MATRIX_A   = 32'h9908_b0df;
  localparam logic [31:0] UPPER_MASK = 32'h8000_0000;
  localparam logic [31:0] LOWER_MASK = 32'h7fff_ffff;
  localparam logic [31:0] TEMPER_B   = 32'h9d2c_5680;
  localparam logic [31:0] TEMPER_C   = 32'hefc6_0000;

  // Temper one table word into an output word
  function automatic logic [31:0] temper(input logic [31:0] x);
    logic [31:0] y;
    y = x ^ (x >> 11);
    y = y ^ ((y << 7) & TEMPER_B);
    y = y ^ ((y << 15) & TEMPER_C);
    y = y ^ (y >> 18);
    return y;
  endfunction

endpackage

`default_nettype wire

### design/mersenne_twister_generator_unit.sv
// Channel  | Direction | Handshake               | Payload
// request  | in        | in_valid_i / in_stall_o  | req_type_i, seed_word_i
// result   | out       | out_valid_o / out_stall_i| random_word_o, is_seeded_o
//
// A draw: accept, then one synchronous read of the state table, then tempering.
// When the read pointer wraps, a twist pass runs first; it is one table entry per
// cycle through two read ports and one write port.
// A seed fills the table at one entry per cycle, then twists.
// Reset clears the sequencer, pointer and seeded flag; the table holds garbage
// until the first seed. A stalled result is held while the next request is taken.
`default_nettype none

`include "mersenne_twister_generator_unit_defines.svh"

module mersenne_twister_generator_unit
  import mtg_pkg::*;
#(
  parameter int unsigned TableDepth = 624
) (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        in_valid_i,
  output logic             in_stall_o,
  input  wire logic        req_type_i,
  input  wire logic [31:0] seed_word_i,
  output logic             out_valid_o,
  input  wire logic        out_stall_i,
  output logic [31:0]      random_word_o,
  output logic             is_seeded_o
);

  localparam int unsigned IdxW = $clog2(TableDepth);
  localparam int unsigned CntW = $clog2(TableDepth + 1);

  localparam logic [1:0] ST_IDLE  = 2'd0;
  localparam logic [1:0] ST_SEED  = 2'd1;
  localparam logic [1:0] ST_TWIST = 2'd2;
  localparam logic [1:0] ST_DRAW  = 2'd3;

  logic [1:0]      state_q, state_d;
  logic [CntW-1:0] cnt_q, cnt_d;
  logic            pipe_q, pipe_d;
  logic [IdxW-1:0] ptr_q, ptr_d;
  logic            seeded_q, seeded_d;
  logic            zero_q, zero_d;
  logic [31:0]     prev_q, prev_d;
  logic [31:0]     cur_q, cur_d;
  logic            out_valid_q, out_valid_d;
  logic [31:0]     out_word_q, out_word_d;
  logic            out_seeded_q, out_seeded_d;

  logic [31:0]     mem [TableDepth];
  logic [31:0]     rd_a_q, rd_b_q;
  logic [IdxW-1:0] addr_a, addr_b;
  logic            mem_we;
  logic [IdxW-1:0] mem_wa;
  logic [31:0]     mem_wd;

  logic            accept;
  logic            out_free;
  logic [31:0]     seed_mix;
  logic [31:0]     seed_val;
  logic [31:0]     twist_y;
  logic [31:0]     twist_val;
  logic [CntW-1:0] nxt_idx;
  logic [CntW-1:0] far_idx;

  assign accept   = in_valid_i && !in_stall_o;
  assign out_free = !out_valid_q || !out_stall_i;

  // Seed recurrence for the entry at cnt_q
  assign seed_mix = prev_q ^ (prev_q >> 30);
  assign seed_val = (INIT_MULT * seed_mix) + 32'(cnt_q);

  // Twist recurrence for the entry at cnt_q - 1
  assign twist_y   = (cur_q & UPPER_MASK) | (rd_a_q & LOWER_MASK);
  assign twist_val = rd_b_q ^ (twist_y >> 1) ^ (twist_y[0] ? MATRIX_A : 32'd0);

  // Neighbour and far indexes of the step whose reads go out now
  assign nxt_idx = (cnt_q == CntW'(TableDepth - 1)) ? '0 : cnt_q + CntW'(1);
  assign far_idx = (cnt_q < CntW'(TableDepth - SHIFT_M)) ? cnt_q + CntW'(SHIFT_M)
                                                        : cnt_q - CntW'(TableDepth - SHIFT_M);

  // Select read addresses
  always_comb begin
    addr_a = ptr_q;
    addr_b = far_idx[IdxW-1:0];
    if (state_q == ST_TWIST && cnt_q < CntW'(TableDepth)) begin
      addr_a = nxt_idx[IdxW-1:0];
    end
  end

  // Select write port
  always_comb begin
    mem_we = 1'b0;
    mem_wa = cnt_q[IdxW-1:0];
    mem_wd = seed_val;
    case (state_q)
      ST_IDLE: begin
        if (accept && req_type_i == REQ_SEED) begin
          mem_we = 1'b1;
          mem_wa = '0;
          mem_wd = seed_word_i;
        end
      end
      ST_SEED: begin
        mem_we = 1'b1;
      end
      ST_TWIST: begin
        mem_we = pipe_q;
        mem_wa = IdxW'(cnt_q - CntW'(1));
        mem_wd = twist_val;
      end
      default: begin
        mem_we = 1'b0;
      end
    endcase
  end

  // State table: one write, two registered reads
  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      mem[mem_wa] <= mem_wd;
    end
    rd_a_q <= mem[addr_a];
    rd_b_q <= mem[addr_b];
  end

  // Sequence seeding, twisting and draws
  always_comb begin
    state_d      = state_q;
    cnt_d        = cnt_q;
    pipe_d       = pipe_q;
    ptr_d        = ptr_q;
    seeded_d     = seeded_q;
    zero_d       = zero_q;
    prev_d       = prev_q;
    cur_d        = cur_q;
    out_valid_d  = out_valid_q && out_stall_i;
    out_word_d   = out_word_q;
    out_seeded_d = out_seeded_q;
    case (state_q)
      ST_IDLE: begin
        if (accept) begin
          if (req_type_i == REQ_SEED) begin
            prev_d   = seed_word_i;
            cnt_d    = CntW'(1);
            ptr_d    = '0;
            seeded_d = 1'b1;
            state_d  = ST_SEED;
          end else if (!seeded_q) begin
            zero_d  = 1'b1;
            state_d = ST_DRAW;
          end else if (ptr_q == '0) begin
            cnt_d   = '0;
            pipe_d  = 1'b0;
            state_d = ST_TWIST;
          end else begin
            zero_d  = 1'b0;
            state_d = ST_DRAW;
          end
        end
      end
      ST_SEED: begin
        prev_d = seed_val;
        if (cnt_q == CntW'(TableDepth - 1)) begin
          cnt_d   = '0;
          pipe_d  = 1'b0;
          state_d = ST_TWIST;
        end else begin
          cnt_d = cnt_q + CntW'(1);
        end
      end
      ST_TWIST: begin
        cur_d = rd_a_q;
        if (cnt_q == CntW'(TableDepth)) begin
          zero_d  = 1'b0;
          state_d = ST_DRAW;
        end else begin
          cnt_d  = cnt_q + CntW'(1);
          pipe_d = 1'b1;
        end
      end
      ST_DRAW: begin
        if (out_free) begin
          out_valid_d  = 1'b1;
          out_word_d   = zero_q ? 32'd0 : temper(rd_a_q);
          out_seeded_d = seeded_q;
          if (!zero_q) begin
            ptr_d = (ptr_q == IdxW'(TableDepth - 1)) ? '0 : ptr_q + IdxW'(1);
          end
          state_d = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  // Hold control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      cnt_q       <= '0;
      pipe_q      <= 1'b0;
      ptr_q       <= '0;
      seeded_q    <= 1'b0;
      zero_q      <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      cnt_q       <= cnt_d;
      pipe_q      <= pipe_d;
      ptr_q       <= ptr_d;
      seeded_q    <= seeded_d;
      zero_q      <= zero_d;
      out_valid_q <= out_valid_d;
    end
  end

  // Hold payload
  always_ff @(posedge clk_i) begin
    prev_q       <= prev_d;
    cur_q        <= cur_d;
    out_word_q   <= out_word_d;
    out_seeded_q <= out_seeded_d;
  end

  assign in_stall_o    = (state_q != ST_IDLE);
  assign out_valid_o   = out_valid_q;
  assign random_word_o = out_word_q;
  assign is_seeded_o   = out_seeded_q;

  `MTG_ASSERT_NOW(a_ptr_range, 1'b1, ptr_q < IdxW'(TableDepth))
  `MTG_ASSERT_NOW(a_unseeded_zero, out_valid_q && !out_seeded_q, out_word_q == 32'd0)
  `MTG_ASSERT_NOW(a_twist_no_clash, state_q == ST_TWIST && mem_we && cnt_q < CntW'(TableDepth),
                  mem_wa != addr_a && mem_wa != addr_b)
  `MTG_ASSERT_NEXT(a_busy_after_accept, accept, state_q != ST_IDLE)

endmodule

`default_nettype wire

### sim/tb_top.sv
`timescale 1ns / 100ps

module tb_top;
  import mtg_pkg::*;

  localparam int unsigned GenDepth   = 624;
  localparam int unsigned CycleLimit = 500000;
  localparam int unsigned DrainWait  = 50;
  localparam int unsigned IdlePct    = 18;
  localparam int unsigned HoldAt     = 450;
  localparam int unsigned HoldLength = 250;
  localparam int unsigned CalmFrom   = 150;
  localparam int unsigned CalmTo     = 300;

  typedef struct packed {
    logic        kind;
    logic [31:0] seed;
  } gen_request_t;

  typedef struct packed {
    logic [31:0] word;
    logic        seeded;
  } gen_result_t;

  // Clock, reset and block ports
  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        in_valid = 1'b0;
  logic        in_stall_o;
  logic        req_type = REQ_DRAW;
  logic [31:0] seed_word = '0;
  logic        out_valid_o;
  logic        out_stall = 1'b0;
  logic [31:0] random_word_o;
  logic        is_seeded_o;

  // Generator copy used for prediction
  logic [31:0] gen_table [GenDepth];
  int unsigned gen_index;
  logic        gen_seeded;

  gen_request_t pending_reqs [$];
  gen_result_t  expected_words [$];

  int unsigned reqs_taken = 0;
  int unsigned results_taken = 0;
  int unsigned hold_left = 0;
  bit          hold_done = 1'b0;
  int unsigned error_count = 0;
  int unsigned cycle_count = 0;

  mersenne_twister_generator_unit DUT (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (in_valid),
    .in_stall_o   (in_stall_o),
    .req_type_i   (req_type),
    .seed_word_i  (seed_word),
    .out_valid_o  (out_valid_o),
    .out_stall_i  (out_stall),
    .random_word_o(random_word_o),
    .is_seeded_o  (is_seeded_o)
  );

  always #5 clk_i = ~clk_i;

  // Temper a table word into an output word
  function automatic logic [31:0] temper_word(input logic [31:0] w);
    logic [31:0] t;
    t = w ^ (w >> 11);
    t = t ^ ((t << 7) & TEMPER_B);
    t = t ^ ((t << 15) & TEMPER_C);
    t = t ^ (t >> 18);
    return t;
  endfunction

  // Regenerate the whole table in place
  task automatic twist_gen_table();
    int unsigned nxt;
    int unsigned far;
    logic [31:0] y;
    logic [31:0] v;
    for (int unsigned i = 0; i < GenDepth; i++) begin
      nxt = (i + 1) % GenDepth;
      far = (i + SHIFT_M) % GenDepth;
      y = (gen_table[i] & UPPER_MASK) | (gen_table[nxt] & LOWER_MASK);
      v = gen_table[far] ^ (y >> 1);
      if (y[0]) v = v ^ MATRIX_A;
      gen_table[i] = v;
    end
  endtask

  // Work out the result of one accepted request and queue it
  task automatic predict_result(input logic kind, input logic [31:0] seed);
    gen_result_t r;
    logic [31:0] p;
    if (kind == REQ_SEED) begin
      gen_table[0] = seed;
      for (int unsigned i = 1; i < GenDepth; i++) begin
        p = gen_table[i - 1];
        gen_table[i] = INIT_MULT * (p ^ (p >> 30)) + i;
      end
      gen_index  = 0;
      gen_seeded = 1'b1;
    end
    r.word   = '0;
    r.seeded = gen_seeded;
    if (gen_seeded) begin
      if (gen_index == 0) twist_gen_table();
      r.word    = temper_word(gen_table[gen_index]);
      gen_index = (gen_index + 1) % GenDepth;
    end
    expected_words.push_back(r);
  endtask

  task automatic add_request(input logic kind, input logic [31:0] seed);
    gen_request_t q;
    q.kind = kind;
    q.seed = seed;
    pending_reqs.push_back(q);
  endtask

  function automatic logic [31:0] pick_seed();
    case ($urandom_range(7))
      0:       return 32'h0000_0000;
      1:       return 32'hffff_ffff;
      default: return $urandom;
    endcase
  endfunction

  task automatic add_seed_burst(input int unsigned max_draws);
    add_request(REQ_SEED, pick_seed());
    repeat ($urandom_range(max_draws)) add_request(REQ_DRAW, $urandom);
  endtask

  // Request driver: hold a stalled request, otherwise offer the next one
  always @(posedge clk_i or negedge rst_ni) begin : drive_requests
    gen_request_t nxt;
    bit           busy;
    bit           calm;
    if (!rst_ni) begin
      in_valid  <= 1'b0;
      req_type  <= REQ_DRAW;
      seed_word <= '0;
    end else begin
      busy = in_valid;
      if (in_valid && !in_stall_o) begin
        predict_result(req_type, seed_word);
        reqs_taken++;
        busy = 1'b0;
      end
      calm = (reqs_taken >= CalmFrom) && (reqs_taken < CalmTo);
      if (!busy) begin
        if (pending_reqs.size() > 0 && (calm || $urandom_range(99) >= IdlePct)) begin
          nxt = pending_reqs.pop_front();
          in_valid  <= 1'b1;
          req_type  <= nxt.kind;
          seed_word <= nxt.seed;
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // Result monitor: check each accepted result against the oldest expectation
  always @(posedge clk_i or negedge rst_ni) begin : check_results
    gen_result_t e;
    bit          calm;
    if (!rst_ni) begin
      out_stall <= 1'b0;
    end else begin
      if (out_valid_o && !out_stall) begin
        if (expected_words.size() == 0) begin
          $display("%0t: unexpected result: word %h seeded %b",
                   $time, random_word_o, is_seeded_o);
          error_count++;
        end else begin
          e = expected_words.pop_front();
          if (random_word_o !== e.word) begin
            $display("%0t: random_word expected %h actual %h",
                     $time, e.word, random_word_o);
            error_count++;
          end
          if (is_seeded_o !== e.seeded) begin
            $display("%0t: is_seeded expected %b actual %b",
                     $time, e.seeded, is_seeded_o);
            error_count++;
          end
        end
        results_taken++;
      end
      // Hold off once for a long stretch so the block backs up
      if (!hold_done && results_taken == HoldAt) begin
        hold_left = HoldLength;
        hold_done = 1'b1;
      end
      calm = (results_taken >= CalmFrom) && (results_taken < CalmTo);
      if (hold_left > 0) begin
        out_stall <= 1'b1;
        hold_left--;
      end else begin
        out_stall <= !calm && ($urandom_range(99) < IdlePct);
      end
    end
  end

  // Abort on a hung run
  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count > CycleLimit) begin
      $display("status: fail");
      $finish;
    end
  end

  initial begin
    for (int unsigned i = 0; i < GenDepth; i++) gen_table[i] = '0;
    gen_index  = 0;
    gen_seeded = 1'b0;

    // Draws before any seed, then seeds at the extremes and a reseed
    add_request(REQ_DRAW, 32'h0000_0000);
    add_request(REQ_DRAW, 32'hffff_ffff);
    add_request(REQ_SEED, 32'd5489);
    repeat (3) add_request(REQ_DRAW, 32'h0000_0000);
    add_request(REQ_SEED, 32'h0000_0000);
    repeat (2) add_request(REQ_DRAW, 32'hffff_ffff);
    add_request(REQ_SEED, 32'hffff_ffff);
    repeat (2) add_request(REQ_DRAW, 32'h5555_5555);
    add_request(REQ_SEED, 32'h8000_0000);
    add_request(REQ_DRAW, 32'haaaa_aaaa);
    add_request(REQ_SEED, 32'h0000_0001);
    add_request(REQ_SEED, 32'h0000_0001);
    add_request(REQ_DRAW, 32'hffff_ffff);

    // Short seeded bursts, then a draw run long enough to wrap the table
    repeat (12) add_seed_burst(12);
    add_request(REQ_SEED, $urandom);
    repeat (680) add_request(REQ_DRAW, $urandom);
    repeat (4) add_seed_burst(8);

    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;

    // Wait for every request to go in and every result to come back
    do @(posedge clk_i);
    while (pending_reqs.size() != 0 || in_valid || expected_words.size() != 0);
    repeat (DrainWait) @(posedge clk_i);

    if (expected_words.size() != 0)
      $display("%0t: %0d results never arrived", $time, expected_words.size());
    if (error_count == 0 && expected_words.size() == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule

### sim.f
+incdir+design
design/mtg_pkg.sv
design/mersenne_twister_generator_unit.sv
sim/tb_top.sv
